// ===== sv/sha256_pkg.sv =====
package sha256_pkg;

    // Eight 32-bit words, index 0 is the most significant digest word
    typedef logic [0:7][31:0] t_words;

    // Controls from the sequencer to the round unit
    typedef struct packed {
        logic load;   // copy hash words into the working variables
        logic step;   // run one compression round
        logic fold;   // add working variables into the hash words
        logic init;   // restart from the initial hash values
    } t_rnd_ctl;

    localparam t_words H_INIT = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    function automatic logic [31:0] big_sig0(input logic [31:0] a);
        return {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] e);
        return {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] y);
        return {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ {10'd0, y[31:10]};
    endfunction

    // Round constants
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/sha256_hash_engine_core.sv =====
// Channel  | Direction | Handshake          | Beat payload
// ---------+-----------+--------------------+-------------------------------------------
// input    | in        | i_valid / o_stall  | i_data_word, i_byte_count, i_final_word
// output   | out       | o_valid / i_stall  | o_digest_word, o_word_index, o_digest_end
//
// A word is taken in S_IDLE and written into the block in S_BYTE, whole when it is
// four bytes on a word boundary, otherwise one byte per cycle while the block is not full.
// Each full 64-byte block is compressed in the shared round unit (64 rounds, one fold).
// A final word adds a padding step and a compression for each padding block
// (one or two), then eight digest beats.
// Reset is synchronous, active low; it clears the sequencer and restores the initial hash.
// o_stall is high whenever the engine is busy; i_stall holds the current digest beat.
module sha256_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_final_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_end
);
    import sha256_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_BYTE = 7'b0000010,
        S_PAD  = 7'b0000100,
        S_PAD2 = 7'b0001000,
        S_COMP = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_state w_after;

    logic [0:15][31:0] r_blk, n_blk;
    logic [31:0]       r_word, n_word;
    logic [2:0]        r_left, n_left;
    logic              r_final, n_final;
    logic [63:0]       r_bits, n_bits;
    logic [5:0]        r_fill, n_fill;
    logic [5:0]        r_round, n_round;
    logic [2:0]        r_idx, n_idx;

    logic       w_in_acc;
    logic [2:0] w_cnt;
    logic [31:0] w_sched;
    t_rnd_ctl   w_ctl;
    t_words     w_hash;

    assign w_in_acc = i_valid && !o_stall;
    assign w_cnt    = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
    assign w_sched  = small_sig1(r_blk[14]) + r_blk[9] + small_sig0(r_blk[1]) + r_blk[0];

    // Sequencer: fill, pad, compress, emit
    always_comb begin
        logic [5:0] v_pos;
        n_state = r_state;
        n_ret   = r_ret;
        n_blk   = r_blk;
        n_word  = r_word;
        n_left  = r_left;
        n_final = r_final;
        n_bits  = r_bits;
        n_fill  = r_fill;
        n_round = r_round;
        n_idx   = r_idx;
        w_ctl   = '0;
        w_after = S_IDLE;
        v_pos   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_word  = i_data_word;
                    n_left  = w_cnt;
                    n_final = i_final_word;
                    n_bits  = r_bits + {58'd0, w_cnt, 3'd0};
                    if (w_cnt != 3'd0) begin
                        n_state = S_BYTE;
                    end else if (i_final_word) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_BYTE: begin
                // Whole aligned word in one go, otherwise one byte
                if (r_fill[1:0] == 2'd0 && r_left == 3'd4) begin
                    n_blk[r_fill[5:2]] = r_word;
                    n_fill = r_fill + 6'd4;
                    n_left = 3'd0;
                end else begin
                    case (r_fill[1:0])
                        2'd0:    n_blk[r_fill[5:2]][31:24] = r_word[31:24];
                        2'd1:    n_blk[r_fill[5:2]][23:16] = r_word[31:24];
                        2'd2:    n_blk[r_fill[5:2]][15:8]  = r_word[31:24];
                        default: n_blk[r_fill[5:2]][7:0]   = r_word[31:24];
                    endcase
                    n_fill = r_fill + 6'd1;
                    n_left = r_left - 3'd1;
                    n_word = {r_word[23:0], 8'd0};
                end
                if (n_left != 3'd0) begin
                    w_after = S_BYTE;
                end else if (r_final) begin
                    w_after = S_PAD;
                end else begin
                    w_after = S_IDLE;
                end
                // Block full: compress before taking more bytes
                if (n_fill == 6'd0) begin
                    n_state    = S_COMP;
                    n_ret      = w_after;
                    w_ctl.load = 1'b1;
                end else begin
                    n_state = w_after;
                end
            end
            S_PAD: begin
                // Marker byte at the fill point, zeros after it
                for (int w = 0; w < 16; w++) begin
                    for (int b = 0; b < 4; b++) begin
                        v_pos = 6'(w * 4 + b);
                        if (v_pos == r_fill) begin
                            n_blk[w][31 - 8 * b -: 8] = PAD_BYTE;
                        end else if (v_pos > r_fill) begin
                            n_blk[w][31 - 8 * b -: 8] = 8'h00;
                        end
                    end
                end
                if (r_fill < LEN_START) begin
                    n_blk[14] = r_bits[63:32];
                    n_blk[15] = r_bits[31:0];
                    n_ret     = S_OUT;
                end else begin
                    n_ret = S_PAD2;
                end
                n_state    = S_COMP;
                w_ctl.load = 1'b1;
            end
            S_PAD2: begin
                // Extra block: zeros and the length
                for (int w = 0; w < 14; w++) begin
                    n_blk[w] = 32'd0;
                end
                n_blk[14]  = r_bits[63:32];
                n_blk[15]  = r_bits[31:0];
                n_ret      = S_OUT;
                n_state    = S_COMP;
                w_ctl.load = 1'b1;
            end
            S_COMP: begin
                // Run a round and slide the schedule window
                w_ctl.step = 1'b1;
                for (int w = 0; w < 15; w++) begin
                    n_blk[w] = r_blk[w + 1];
                end
                n_blk[15] = w_sched;
                n_round   = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                w_ctl.fold = 1'b1;
                n_state    = r_ret;
            end
            S_OUT: begin
                // Advance on each delivered digest beat
                if (!i_stall) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        w_ctl.init = 1'b1;
                        n_bits     = '0;
                        n_fill     = '0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_left  <= '0;
            r_final <= 1'b0;
            r_bits  <= '0;
            r_fill  <= '0;
            r_round <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_left  <= n_left;
            r_final <= n_final;
            r_bits  <= n_bits;
            r_fill  <= n_fill;
            r_round <= n_round;
            r_idx   <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_word <= n_word;
    end

    sha256_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_w     (r_blk[0]),
        .i_k_idx (r_round),
        .o_hash  (w_hash)
    );

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = w_hash[r_idx];
    assign o_word_index  = r_idx;
    assign o_digest_end  = (r_idx == 3'd7);

    a_first_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_word_index == 3'd0)
        else $error("digest does not start at word 0");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while digest pending");

    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_COMP |-> r_round == 6'd0)
        else $error("round counter not at zero outside compression");

    a_byte_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BYTE |-> r_left != 3'd0)
        else $error("byte state with nothing left to write");

    a_fold_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> $past(r_state) == S_COMP)
        else $error("fold without a finished compression");

endmodule

// ===== sv/sha256_round.sv =====
module sha256_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256_pkg::t_rnd_ctl i_ctl,
    input  logic [31:0]         i_w,
    input  logic [5:0]          i_k_idx,
    output sha256_pkg::t_words  o_hash
);
    import sha256_pkg::*;

    t_words r_hash;
    t_words r_wv;
    t_words n_wv;

    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;

    // One compression round on the working variables a..h
    always_comb begin
        w_ch  = (r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]);
        w_maj = (r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]);
        w_t1  = r_wv[7] + big_sig1(r_wv[4]) + w_ch + round_k(i_k_idx) + i_w;
        w_t2  = big_sig0(r_wv[0]) + w_maj;
        n_wv[0] = w_t1 + w_t2;
        n_wv[1] = r_wv[0];
        n_wv[2] = r_wv[1];
        n_wv[3] = r_wv[2];
        n_wv[4] = r_wv[3] + w_t1;
        n_wv[5] = r_wv[4];
        n_wv[6] = r_wv[5];
        n_wv[7] = r_wv[6];
    end

    // Hold the chaining value; fold in each finished block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= H_INIT;
        end else if (i_ctl.init) begin
            r_hash <= H_INIT;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= r_hash[i] + r_wv[i];
            end
        end
    end

    // Load or advance the working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_wv <= r_hash;
        end else if (i_ctl.step) begin
            r_wv <= n_wv;
        end
    end

    assign o_hash = r_hash;

endmodule
